// ----- design/sbmu_pkg.sv -----
// Shared types and constants of the segmented byte memory unit.
`default_nettype none

package sbmu_pkg;

    localparam int MEM_BYTES     = 16384;
    localparam int SEGMENT_COUNT = 8;
    localparam int ENTRY_REGS    = 8;
    localparam int SEG_IDX_W     = $clog2(ENTRY_REGS);
    localparam int CFG_ADDR_W    = SEG_IDX_W + 2;
    localparam int BANK_COUNT    = 4;
    localparam int BANK_SEL_W    = 2;
    localparam int BANK_ROWS     = MEM_BYTES / BANK_COUNT;
    localparam int ROW_W         = $clog2(BANK_ROWS);
    localparam int QUEUE_DEPTH   = 2;
    localparam int QPTR_W        = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W        = $clog2(QUEUE_DEPTH + 1);

    localparam logic [31:0] ENTRY_UNASSIGNED = 32'hFFFF_FFFF;

    typedef enum logic [1:0] {
        OP_READ  = 2'd0,
        OP_WRITE = 2'd1,
        OP_LOAD  = 2'd2,
        OP_NONE  = 2'd3
    } op_t;

    typedef enum logic [2:0] {
        FAULT_NONE       = 3'd0,
        FAULT_BAD_COUNT  = 3'd1,
        FAULT_BAD_SEG    = 3'd2,
        FAULT_PAST_SEG   = 3'd3,
        FAULT_PAST_MEM   = 3'd4,
        FAULT_LOAD_RANGE = 3'd5
    } fault_t;

    typedef logic [ENTRY_REGS-1:0][31:0] seg_table_t;

    // One classified access as it travels from the front to the back.
    typedef struct packed {
        logic        rd;
        logic        wr;
        logic [15:0] phys;
        logic [2:0]  count;
        logic [31:0] wdata;
        fault_t      fault;
    } cmd_t;

endpackage

`default_nettype wire

// ----- design/sbmu_cfg.sv -----
// Segment descriptor registers behind the APB-style configuration port.
`default_nettype none

module sbmu_cfg (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           psel,
    input  wire logic                           penable,
    input  wire logic                           pwrite,
    input  wire logic [sbmu_pkg::CFG_ADDR_W-1:0] paddr,
    input  wire logic [31:0]                    pwdata,
    output logic      [31:0]                    prdata,
    output logic                                pready,
    output sbmu_pkg::seg_table_t                seg_table
);
    import sbmu_pkg::*;

    seg_table_t entry_reg;
    logic [SEG_IDX_W-1:0] reg_idx;

    assign reg_idx = paddr[CFG_ADDR_W-1:2];
    assign pready  = 1'b1;
    assign prdata  = entry_reg[reg_idx];
    assign seg_table = entry_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < ENTRY_REGS; i++)
            begin
                entry_reg[i] <= ENTRY_UNASSIGNED;
            end
        end
        else if (psel && penable && pwrite)
        begin
            entry_reg[reg_idx] <= pwdata;
        end
    end

endmodule

`default_nettype wire

// ----- design/sbmu_front.sv -----
// Front end: translates the address, checks the bounds and classifies each word.
`default_nettype none

module sbmu_front (
    input  wire logic                 in_valid,
    output logic                      in_stall,
    input  wire logic [1:0]           operation,
    input  wire logic [31:0]          address,
    input  wire logic [2:0]           byte_count,
    input  wire logic [31:0]          write_data,
    input  wire sbmu_pkg::seg_table_t seg_table,
    input  wire logic                 q_full,
    input  wire logic                 clearing,
    output logic                      push,
    output sbmu_pkg::cmd_t            cmd
);
    import sbmu_pkg::*;

    logic [15:0] seg_code;
    logic [15:0] offset;
    logic [31:0] entry;
    logic        count_ok;
    logic        seg_ok;
    logic [16:0] phys_sum;
    logic [16:0] seg_end;
    logic [17:0] mem_end;
    op_t         op;

    assign op       = op_t'(operation);
    assign seg_code = address[31:16];
    assign offset   = address[15:0];
    assign entry    = seg_table[address[16 +: SEG_IDX_W]];
    assign count_ok = (byte_count >= 3'd1) && (byte_count <= 3'd4);
    assign seg_ok   = (seg_code < 16'(SEGMENT_COUNT)) && (entry != ENTRY_UNASSIGNED);
    assign phys_sum = {1'b0, entry[31:16]} + {1'b0, offset};
    assign seg_end  = {1'b0, offset} + 17'(byte_count);
    assign mem_end  = {1'b0, phys_sum} + 18'(byte_count);

    assign in_stall = clearing | q_full;
    assign push     = in_valid & ~in_stall;

    always_comb
    begin
        cmd       = '0;
        cmd.fault = FAULT_NONE;
        unique case (op) inside
            OP_LOAD:
            begin
                cmd.phys = address[15:0];
                if (address >= 32'(MEM_BYTES))
                begin
                    cmd.fault = FAULT_LOAD_RANGE;
                end
                else
                begin
                    // A loader store is a one-byte write of the low data byte.
                    cmd.wr    = 1'b1;
                    cmd.count = 3'd1;
                    cmd.wdata = {24'd0, write_data[7:0]};
                end
            end
            OP_READ, OP_WRITE:
            begin
                if (!count_ok)
                begin
                    cmd.fault = FAULT_BAD_COUNT;
                end
                else if (!seg_ok)
                begin
                    cmd.fault = FAULT_BAD_SEG;
                end
                else
                begin
                    cmd.phys = phys_sum[15:0];
                    if (seg_end > {1'b0, entry[15:0]})
                    begin
                        cmd.fault = FAULT_PAST_SEG;
                    end
                    else if (mem_end > 18'(MEM_BYTES))
                    begin
                        cmd.fault = FAULT_PAST_MEM;
                    end
                    else
                    begin
                        cmd.rd    = (op == OP_READ);
                        cmd.wr    = (op == OP_WRITE);
                        cmd.count = byte_count;
                        cmd.wdata = write_data;
                    end
                end
            end
            OP_NONE:
            begin
                cmd.fault = FAULT_NONE;
            end
        endcase
    end

endmodule

`default_nettype wire

// ----- design/sbmu_queue.sv -----
// Short command queue between the front end and the memory back end.
`default_nettype none

module sbmu_queue (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           push,
    input  wire sbmu_pkg::cmd_t cmd_in,
    input  wire logic           pop,
    output sbmu_pkg::cmd_t      cmd_out,
    output logic                full,
    output logic                empty
);
    import sbmu_pkg::*;

    cmd_t              slot_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_next;
    logic [QCNT_W-1:0] count_reg;
    logic [QCNT_W-1:0] count_next;

    assign full    = (count_reg == QCNT_W'(QUEUE_DEPTH));
    assign empty   = (count_reg == '0);
    assign cmd_out = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= cmd_in;
        end
    end

endmodule

`default_nettype wire

// ----- design/sbmu_back.sv -----
// Back end: four byte-interleaved banks, the clearing pass and the result register.
`default_nettype none

module sbmu_back (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           q_empty,
    input  wire sbmu_pkg::cmd_t q_cmd,
    output logic                pop,
    output logic                clearing,
    output logic                out_valid,
    input  wire logic           out_stall,
    output logic [31:0]         read_data,
    output logic [15:0]         physical_address,
    output logic [2:0]          fault
);
    import sbmu_pkg::*;

    logic             clear_reg;
    logic             clear_next;
    logic [ROW_W-1:0] clr_row_reg;
    logic [ROW_W-1:0] clr_row_next;
    logic             mem_valid_reg;
    logic             mem_valid_next;
    cmd_t             mem_cmd_reg;
    logic             out_valid_reg;
    logic             out_valid_next;
    logic [31:0]      out_data_reg;
    logic [15:0]      out_phys_reg;
    fault_t           out_fault_reg;
    logic             out_free;
    logic             mem_advance;
    logic             out_load;
    logic [31:0]      asm_data;

    logic             bank_we   [BANK_COUNT];
    logic             bank_re   [BANK_COUNT];
    logic [ROW_W-1:0] bank_addr [BANK_COUNT];
    logic [7:0]       bank_wd   [BANK_COUNT];
    logic [7:0]       rd_data_reg [BANK_COUNT];

    assign out_free    = !out_valid_reg || !out_stall;
    assign mem_advance = !mem_valid_reg || out_free;
    assign pop         = !q_empty && !clear_reg && mem_advance;
    assign out_load    = mem_valid_reg && out_free;
    assign clearing    = clear_reg;

    assign out_valid        = out_valid_reg;
    assign read_data        = out_data_reg;
    assign physical_address = out_phys_reg;
    assign fault            = out_fault_reg;

    // Byte i of an access sits at phys+i, which lands in bank (phys+i) mod 4.
    always_comb
    begin
        logic [BANK_SEL_W-1:0] k;
        logic                  active;
        logic [2:0]            sh;
        logic [ROW_W-1:0]      row;
        logic [7:0]            wbyte;
        for (int b = 0; b < BANK_COUNT; b++)
        begin
            k      = BANK_SEL_W'(b) - q_cmd.phys[BANK_SEL_W-1:0];
            active = ({1'b0, k} < q_cmd.count);
            sh     = q_cmd.count - 3'd1 - {1'b0, k};
            row    = q_cmd.phys[ROW_W+BANK_SEL_W-1:BANK_SEL_W]
                   + ROW_W'(BANK_SEL_W'(b) < q_cmd.phys[BANK_SEL_W-1:0]);
            wbyte  = q_cmd.wdata[{sh[1:0], 3'b000} +: 8];
            bank_we[b]   = clear_reg || (pop && q_cmd.wr && active);
            bank_re[b]   = pop && q_cmd.rd && active;
            bank_addr[b] = clear_reg ? clr_row_reg : row;
            bank_wd[b]   = clear_reg ? 8'd0 : wbyte;
        end
    end

    for (genvar g = 0; g < BANK_COUNT; g++)
    begin : g_bank
        logic [7:0] bank_mem [BANK_ROWS];

        always_ff @(posedge clk)
        begin
            if (bank_we[g])
            begin
                bank_mem[bank_addr[g]] <= bank_wd[g];
            end
            if (bank_re[g])
            begin
                rd_data_reg[g] <= bank_mem[bank_addr[g]];
            end
        end
    end

    // Put each bank's byte back into its big-endian place in the result.
    always_comb
    begin
        logic [BANK_SEL_W-1:0] k;
        logic [2:0]            sh;
        asm_data = '0;
        for (int b = 0; b < BANK_COUNT; b++)
        begin
            k  = BANK_SEL_W'(b) - mem_cmd_reg.phys[BANK_SEL_W-1:0];
            sh = mem_cmd_reg.count - 3'd1 - {1'b0, k};
            if (mem_cmd_reg.rd && ({1'b0, k} < mem_cmd_reg.count))
            begin
                asm_data[{sh[1:0], 3'b000} +: 8] = rd_data_reg[b];
            end
        end
    end

    always_comb
    begin
        clear_next   = clear_reg;
        clr_row_next = clr_row_reg;
        if (clear_reg)
        begin
            clr_row_next = clr_row_reg + 1'b1;
            if (clr_row_reg == ROW_W'(BANK_ROWS - 1))
            begin
                clear_next = 1'b0;
            end
        end

        if (pop)
        begin
            mem_valid_next = 1'b1;
        end
        else if (mem_advance)
        begin
            mem_valid_next = 1'b0;
        end
        else
        begin
            mem_valid_next = mem_valid_reg;
        end

        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_free)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clear_reg     <= 1'b1;
            clr_row_reg   <= '0;
            mem_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            clear_reg     <= clear_next;
            clr_row_reg   <= clr_row_next;
            mem_valid_reg <= mem_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            mem_cmd_reg <= q_cmd;
        end
        if (out_load)
        begin
            out_data_reg  <= asm_data;
            out_phys_reg  <= mem_cmd_reg.phys;
            out_fault_reg <= mem_cmd_reg.fault;
        end
    end

endmodule

`default_nettype wire

// ----- design/segmented_byte_memory_unit.sv -----
// Top level of the segmented byte memory unit: config registers, front end, queue, back end.
// An accepted word goes through a queue slot, the bank read stage and the result register.
// Throughput: one word per cycle, one access per bank each cycle, while out_stall is low.
// After reset the banks are swept to zero, one row a cycle through all 4096 rows;
// in_stall stays high during that sweep while configuration writes still land.
`default_nettype none

module segmented_byte_memory_unit (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            psel,
    input  wire logic                            penable,
    input  wire logic                            pwrite,
    input  wire logic [sbmu_pkg::CFG_ADDR_W-1:0] paddr,
    input  wire logic [31:0]                     pwdata,
    output logic      [31:0]                     prdata,
    output logic                                 pready,
    input  wire logic                            in_valid,
    output logic                                 in_stall,
    input  wire logic [1:0]                      operation,
    input  wire logic [31:0]                     address,
    input  wire logic [2:0]                      byte_count,
    input  wire logic [31:0]                     write_data,
    output logic                                 out_valid,
    input  wire logic                            out_stall,
    output logic      [31:0]                     read_data,
    output logic      [15:0]                     physical_address,
    output logic      [2:0]                      fault
);
    import sbmu_pkg::*;

    seg_table_t seg_table;
    cmd_t       front_cmd;
    cmd_t       head_cmd;
    logic       push;
    logic       pop;
    logic       q_full;
    logic       q_empty;
    logic       clearing;

    sbmu_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready),
        .seg_table (seg_table)
    );

    sbmu_front u_front (
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .operation  (operation),
        .address    (address),
        .byte_count (byte_count),
        .write_data (write_data),
        .seg_table  (seg_table),
        .q_full     (q_full),
        .clearing   (clearing),
        .push       (push),
        .cmd        (front_cmd)
    );

    sbmu_queue u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (push),
        .cmd_in  (front_cmd),
        .pop     (pop),
        .cmd_out (head_cmd),
        .full    (q_full),
        .empty   (q_empty)
    );

    sbmu_back u_back (
        .clk              (clk),
        .rst_n            (rst_n),
        .q_empty          (q_empty),
        .q_cmd            (head_cmd),
        .pop              (pop),
        .clearing         (clearing),
        .out_valid        (out_valid),
        .out_stall        (out_stall),
        .read_data        (read_data),
        .physical_address (physical_address),
        .fault            (fault)
    );

endmodule

`default_nettype wire

// ----- sim/tb_segmented_byte_memory_unit.sv -----
// Self-checking testbench for the segmented byte memory unit.
`timescale 1ns / 100ps

module tb_segmented_byte_memory_unit;

    import sbmu_pkg::*;

    localparam int CYCLE_LIMIT      = 200000;
    localparam int HOLD_CYCLES      = 100;
    localparam int DRAIN_CYCLES     = 8;
    localparam int RANDOM_PER_PHASE = 200;

    typedef struct {
        op_t         op;
        logic [31:0] addr;
        logic [2:0]  cnt;
        logic [31:0] wdata;
    } access_t;

    typedef struct {
        logic [31:0] data;
        logic [15:0] phys;
        fault_t      flt;
    } access_result_t;

    logic                  clk        = 1'b0;
    logic                  rst_n      = 1'b0;
    logic                  psel       = 1'b0;
    logic                  penable    = 1'b0;
    logic                  pwrite     = 1'b0;
    logic [CFG_ADDR_W-1:0] paddr      = '0;
    logic [31:0]           pwdata     = '0;
    logic [31:0]           prdata;
    logic                  pready;
    logic                  in_valid   = 1'b0;
    logic                  in_stall;
    logic [1:0]            operation  = '0;
    logic [31:0]           address    = '0;
    logic [2:0]            byte_count = '0;
    logic [31:0]           write_data = '0;
    logic                  out_valid;
    logic                  out_stall  = 1'b0;
    logic [31:0]           read_data;
    logic [15:0]           physical_address;
    logic [2:0]            fault;

    // Shadow copies of the block's memory and segment table.
    logic [7:0]  mem_shadow [MEM_BYTES];
    logic [31:0] seg_shadow [ENTRY_REGS];

    access_t        queued_accesses[$];
    access_result_t predicted_replies[$];

    int tx_idle_pct   = 0;
    int rx_stall_pct  = 0;
    int hold_request  = 0;
    int hold_served   = 0;
    int hold_cnt      = 0;
    int cycle_count   = 0;
    int mismatch_count = 0;

    segmented_byte_memory_unit i_dut (
        .clk              (clk),
        .rst_n            (rst_n),
        .psel             (psel),
        .penable          (penable),
        .pwrite           (pwrite),
        .paddr            (paddr),
        .pwdata           (pwdata),
        .prdata           (prdata),
        .pready           (pready),
        .in_valid         (in_valid),
        .in_stall         (in_stall),
        .operation        (operation),
        .address          (address),
        .byte_count       (byte_count),
        .write_data       (write_data),
        .out_valid        (out_valid),
        .out_stall        (out_stall),
        .read_data        (read_data),
        .physical_address (physical_address),
        .fault            (fault)
    );

    always #5 clk = ~clk;

    task automatic note_mismatch(input string msg);
        $display("[%0t] MISMATCH: %s", $realtime, msg);
        mismatch_count++;
    endtask

    // Works out the reply to one access and applies its effect to the shadow memory.
    function automatic access_result_t access_memory(input access_t w);
        access_result_t r;
        int          seg;
        int          off;
        int          base;
        int          size;
        int          phys;
        int          cnt;
        logic [31:0] entry;
        r.data = '0;
        r.phys = '0;
        r.flt  = FAULT_NONE;
        seg    = w.addr[31:16];
        off    = w.addr[15:0];
        cnt    = w.cnt;
        case (w.op)
            OP_NONE: ;
            OP_LOAD:
            begin
                r.phys = w.addr[15:0];
                if (w.addr >= MEM_BYTES)
                    r.flt = FAULT_LOAD_RANGE;
                else
                    mem_shadow[w.addr] = w.wdata[7:0];
            end
            default:
            begin
                if (cnt < 1 || cnt > 4)
                    r.flt = FAULT_BAD_COUNT;
                else if (seg >= SEGMENT_COUNT)
                    r.flt = FAULT_BAD_SEG;
                else if (seg_shadow[seg] == ENTRY_UNASSIGNED)
                    r.flt = FAULT_BAD_SEG;
                else
                begin
                    entry  = seg_shadow[seg];
                    base   = entry[31:16];
                    size   = entry[15:0];
                    phys   = base + off;
                    r.phys = phys[15:0];
                    if (off + cnt > size)
                        r.flt = FAULT_PAST_SEG;
                    else if (phys + cnt > MEM_BYTES)
                        r.flt = FAULT_PAST_MEM;
                    else if (w.op == OP_READ)
                    begin
                        for (int i = 0; i < cnt; i++)
                            r.data = {r.data[23:0], mem_shadow[phys + i]};
                    end
                    else
                    begin
                        for (int i = 0; i < cnt; i++)
                            mem_shadow[phys + i] = w.wdata[8 * (cnt - 1 - i) +: 8];
                    end
                end
            end
        endcase
        return r;
    endfunction

    // Mostly in-segment reads and writes with random content, some loader
    // stores, and the rest unconstrained noise.
    function automatic access_t make_access();
        access_t w;
        int      kind;
        int      seg;
        int      size;
        int      off;
        int      cnt;
        bit      found;
        w.op    = op_t'($urandom_range(3));
        w.addr  = $urandom();
        w.cnt   = 3'($urandom_range(7));
        w.wdata = $urandom();
        kind    = $urandom_range(99);
        found   = 1'b0;
        seg     = 0;
        if (kind < 78)
        begin
            for (int t = 0; t < 16 && !found; t++)
            begin
                seg = $urandom_range(ENTRY_REGS - 1);
                if (seg_shadow[seg] != ENTRY_UNASSIGNED && seg_shadow[seg][15:0] != 0)
                    found = 1'b1;
            end
        end
        if (found)
        begin
            cnt  = $urandom_range(4, 1);
            size = seg_shadow[seg][15:0];
            if ($urandom_range(9) == 0)
                off = size - cnt + 1;
            else if (size >= cnt)
                off = $urandom_range(size - cnt);
            else
                off = 0;
            if (off < 0)
                off = 0;
            w.op   = $urandom_range(1) ? OP_WRITE : OP_READ;
            w.cnt  = 3'(cnt);
            w.addr = {16'(seg), 16'(off)};
        end
        else if (kind >= 78 && kind < 90)
        begin
            w.op = OP_LOAD;
            if ($urandom_range(7) != 0)
                w.addr = $urandom_range(MEM_BYTES - 1);
        end
        return w;
    endfunction

    task automatic push_access(input op_t op, input logic [31:0] addr, input logic [2:0] cnt,
                               input logic [31:0] wdata);
        access_t w;
        w.op    = op;
        w.addr  = addr;
        w.cnt   = cnt;
        w.wdata = wdata;
        queued_accesses.push_back(w);
    endtask

    task automatic write_segment(input int idx, input logic [31:0] value);
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= CFG_ADDR_W'(idx * 4);
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(negedge clk);
        seg_shadow[idx] = value;
    endtask

    task automatic load_random_table();
        int          keep;
        logic [31:0] e;
        keep = $urandom_range(ENTRY_REGS - 1);
        for (int i = 0; i < ENTRY_REGS; i++)
        begin
            case (i == keep ? 9 : $urandom_range(9))
                0: e = ENTRY_UNASSIGNED;
                1: e = 32'h0;
                2: e = $urandom();
                3: e = {16'(MEM_BYTES - $urandom_range(64, 1)), 16'($urandom_range(64, 4))};
                default: e = {16'($urandom_range(MEM_BYTES - 1)), 16'($urandom_range(64, 4))};
            endcase
            write_segment(i, e);
        end
    endtask

    task automatic wait_drained();
        while (queued_accesses.size() != 0 || in_valid || predicted_replies.size() != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    task automatic push_random(input int n);
        for (int i = 0; i < n; i++)
            queued_accesses.push_back(make_access());
    endtask

    // Input side: predicts each accepted word and presents the next one.
    always @(posedge clk or negedge rst_n)
    begin : drive_proc
        access_t taken;
        access_t nxt;
        if (!rst_n)
        begin
            in_valid <= 1'b0;
        end
        else
        begin
            if (in_valid && !in_stall)
            begin
                taken.op    = op_t'(operation);
                taken.addr  = address;
                taken.cnt   = byte_count;
                taken.wdata = write_data;
                predicted_replies.push_back(access_memory(taken));
            end
            if (!in_valid || !in_stall)
            begin
                if (queued_accesses.size() != 0 && $urandom_range(99) >= tx_idle_pct)
                begin
                    nxt = queued_accesses.pop_front();
                    in_valid   <= 1'b1;
                    operation  <= nxt.op;
                    address    <= nxt.addr;
                    byte_count <= nxt.cnt;
                    write_data <= nxt.wdata;
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // Long receiver hold-off, started when the stimulus side asks for one.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_cnt <= 0;
        end
        else if (hold_cnt != 0)
        begin
            hold_cnt <= hold_cnt - 1;
        end
        else if (hold_request != hold_served)
        begin
            hold_cnt    <= HOLD_CYCLES;
            hold_served <= hold_request;
        end
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_stall <= 1'b0;
        else
            out_stall <= (hold_cnt != 0) || ($urandom_range(99) < rx_stall_pct);
    end

    always @(posedge clk)
    begin : check_proc
        access_result_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (predicted_replies.size() == 0)
            begin
                note_mismatch($sformatf("unexpected word: data %h phys %h fault %0d",
                                        read_data, physical_address, fault));
            end
            else
            begin
                want = predicted_replies.pop_front();
                if (read_data !== want.data)
                    note_mismatch($sformatf("read_data %h, want %h", read_data, want.data));
                if (physical_address !== want.phys)
                    note_mismatch($sformatf("physical_address %h, want %h",
                                            physical_address, want.phys));
                if (fault !== want.flt)
                    note_mismatch($sformatf("fault %0d, want %0d", fault, want.flt));
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("[%0t] timeout with %0d words outstanding", $realtime,
                     predicted_replies.size());
            $display("tb_segmented_byte_memory_unit: done, errors");
            $finish;
        end
    end

    initial
    begin
        for (int i = 0; i < MEM_BYTES; i++)
            mem_shadow[i] = 8'h00;
        for (int i = 0; i < ENTRY_REGS; i++)
            seg_shadow[i] = ENTRY_UNASSIGNED;

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Fixed table with the boundary cases; these writes land during the clearing sweep.
        write_segment(0, 32'h0000_FFFF);
        write_segment(1, 32'h3FF0_0020);
        write_segment(2, 32'h1000_0100);
        write_segment(3, 32'h0000_0000);
        write_segment(4, 32'hFFFF_FFFF);
        write_segment(5, 32'hFFFF_FFFE);
        write_segment(6, 32'h3FFC_0004);
        write_segment(7, 32'h2000_1000);

        tx_idle_pct  = 10;
        rx_stall_pct = 74;

        push_access(OP_LOAD,  32'h0000_0000, 3'd0, 32'h1234_56A5);
        push_access(OP_LOAD,  32'h0000_3FFF, 3'd7, 32'hFFFF_FF5A);
        push_access(OP_LOAD,  32'h0000_4000, 3'd1, 32'h0000_0011);
        push_access(OP_LOAD,  32'hFFFF_FFFF, 3'd4, 32'hFFFF_FFFF);
        push_access(OP_READ,  32'h0000_0000, 3'd4, 32'h0);
        push_access(OP_WRITE, 32'h0006_0000, 3'd4, 32'hDEAD_BEEF);
        push_access(OP_READ,  32'h0006_0000, 3'd4, 32'h0);
        push_access(OP_READ,  32'h0006_0003, 3'd1, 32'h0);
        push_access(OP_WRITE, 32'h0006_0001, 3'd4, 32'h5555_AAAA);
        push_access(OP_READ,  32'h0000_0000, 3'd0, 32'h0);
        push_access(OP_WRITE, 32'h0000_0000, 3'd5, 32'hFFFF_FFFF);
        // A bad count wins over a bad segment.
        push_access(OP_READ,  32'hFFFF_0000, 3'd7, 32'h0);
        push_access(OP_READ,  32'h0008_0000, 3'd1, 32'h0);
        push_access(OP_WRITE, 32'hFFFF_FFFF, 3'd2, 32'h0000_1234);
        push_access(OP_READ,  32'h0004_0000, 3'd1, 32'h0);
        push_access(OP_READ,  32'h0003_0000, 3'd1, 32'h0);
        push_access(OP_READ,  32'h0000_FFFC, 3'd4, 32'h0);
        push_access(OP_READ,  32'h0000_3FFE, 3'd4, 32'h0);
        push_access(OP_READ,  32'h0001_0010, 3'd4, 32'h0);
        // Base plus offset carries past 16 bits here.
        push_access(OP_WRITE, 32'h0005_FFFD, 3'd1, 32'h0000_0077);
        push_access(OP_WRITE, 32'h0002_00FD, 3'd3, 32'h00AB_CDEF);
        push_access(OP_READ,  32'h0002_00FD, 3'd3, 32'h0);
        push_access(OP_NONE,  32'hFFFF_FFFF, 3'd7, 32'hFFFF_FFFF);
        push_access(OP_WRITE, 32'h0007_0000, 3'd2, 32'hFFFF_FFFF);
        push_access(OP_READ,  32'h0007_0000, 3'd2, 32'h0);
        push_access(OP_READ,  32'h0000_3FFC, 3'd4, 32'h0);
        wait_drained();

        load_random_table();
        push_random(RANDOM_PER_PHASE);
        wait_drained();

        tx_idle_pct  = 74;
        rx_stall_pct = 10;
        load_random_table();
        push_random(RANDOM_PER_PHASE);
        wait_drained();

        // No idling; halfway in, the receiver holds off long enough to back up the input.
        tx_idle_pct  = 0;
        rx_stall_pct = 0;
        load_random_table();
        push_random(RANDOM_PER_PHASE);
        while (queued_accesses.size() > RANDOM_PER_PHASE / 2)
            @(negedge clk);
        hold_request = hold_request + 1;
        wait_drained();

        if (mismatch_count == 0)
            $display("tb_segmented_byte_memory_unit: done, clean");
        else
            $display("tb_segmented_byte_memory_unit: done, errors");
        $finish;
    end

endmodule
